@@ hdl/tsm_pkg.sv @@
`timescale 1ns / 1ps
// Package for the three-stack memory block: command and status codes,
// controller states and the control group between controller and datapath.
// No dependencies.
package tsm_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned NUM_STACKS = 3;

    typedef enum logic [1:0] {
        CMD_PEEK = 2'd0,
        CMD_PUSH = 2'd1,
        CMD_POP  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ctrl;

endpackage

@@ hdl/three_stacks_in_one_memory.sv @@
`timescale 1ns / 1ps
// Top level of the three-stack memory block: controller plus datapath.
// Depends on tsm_pkg, tsm_ctrl and tsm_datapath.
//
// Three LIFO stacks of CAPACITY entries each share one memory of
// 3*CAPACITY words. A request is accepted at a rising edge where start is
// high and busy is low; it carries a command (peek, push, pop; code 3 acts
// as peek), a stack number from 1 to 3 and a push value. Stack number 0
// selects nothing and reports an empty stack.
// The block works the request in the cycle after acceptance, reading the
// new top from the memory through its registered read port. The result
// registers and o_valid are loaded at the end of that cycle, and o_valid
// marks the result for exactly one cycle. busy is high for one cycle after
// each accepted request, so none is taken while one is worked; the next
// request may be accepted in the same cycle as the previous result is shown.
// The receiver cannot stall; results must be taken when o_valid is high.
// Synchronous reset clears the fill counters and the controller; memory
// contents are not cleared and busy stays high while reset is held.
module three_stacks_in_one_memory import tsm_pkg::*; #(
    parameter int unsigned CAPACITY = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_command,
    input  logic [1:0]        i_stack_number,
    input  logic [DATA_W-1:0] i_push_value,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_top_value,
    output logic              o_stack_empty,
    output logic [1:0]        o_status
);

    t_ctrl ctrl;

    tsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_ctrl  (ctrl)
    );

    tsm_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_command      (i_command),
        .i_stack_number (i_stack_number),
        .i_push_value   (i_push_value),
        .o_top_value    (o_top_value),
        .o_stack_empty  (o_stack_empty),
        .o_status       (o_status)
    );

endmodule

@@ hdl/tsm_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the three-stack memory block: request handshake and sequencing.
// Depends on tsm_pkg.
module tsm_ctrl import tsm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    output logic  o_valid,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;
    logic   r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= o_ctrl.exec;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_ctrl.load = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_ctrl.exec = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy    = (r_state == ST_EXEC) || !i_rst_n;
    assign o_valid = r_valid;

endmodule

@@ hdl/tsm_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the three-stack memory block: request registers, fill counters,
// the shared entry memory and the result logic. Depends on tsm_pkg.
module tsm_datapath import tsm_pkg::*; #(
    parameter int unsigned CAPACITY = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctrl               i_ctrl,
    input  logic [1:0]          i_command,
    input  logic [1:0]          i_stack_number,
    input  logic [DATA_W-1:0]   i_push_value,
    output logic [DATA_W-1:0]   o_top_value,
    output logic                o_stack_empty,
    output logic [1:0]          o_status
);

    localparam int unsigned DEPTH = NUM_STACKS * CAPACITY;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned FW    = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] BASE2 = AW'(CAPACITY);
    localparam logic [AW-1:0] BASE3 = AW'(2 * CAPACITY);
    localparam logic [FW-1:0] FULL  = FW'(CAPACITY);

    logic [1:0]        r_cmd;
    logic [1:0]        r_sel;
    logic [DATA_W-1:0] r_val;
    logic [FW-1:0]     r_fill [NUM_STACKS];

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic              r_res_empty;
    logic              r_res_bypass;
    t_status           r_res_status;

    logic [AW-1:0] base;
    logic [FW-1:0] fill;
    logic [FW-1:0] new_fill;
    logic          valid_sel;
    logic          wr_en;
    logic          bypass;
    t_status       status;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    always_comb begin
        valid_sel = 1'b1;
        base      = '0;
        fill      = r_fill[0];
        case (r_sel)
            2'd1: begin
                base = '0;
                fill = r_fill[0];
            end
            2'd2: begin
                base = BASE2;
                fill = r_fill[1];
            end
            2'd3: begin
                base = BASE3;
                fill = r_fill[2];
            end
            default: begin
                valid_sel = 1'b0;
            end
        endcase
    end

    always_comb begin
        new_fill = fill;
        wr_en    = 1'b0;
        bypass   = 1'b0;
        status   = STAT_OK;
        case (r_cmd)
            CMD_PUSH: begin
                if (fill == FULL) begin
                    status = STAT_FULL;
                end else begin
                    wr_en    = valid_sel;
                    bypass   = 1'b1;
                    new_fill = fill + FW'(1);
                end
            end
            CMD_POP: begin
                if (fill == '0) begin
                    status = STAT_EMPTY;
                end else begin
                    new_fill = fill - FW'(1);
                end
            end
            default: begin
                new_fill = fill;
            end
        endcase
        if (!valid_sel) begin
            new_fill = '0;
            status   = STAT_OK;
        end
    end

    assign wr_addr = base + AW'(fill);
    assign rd_addr = base + AW'(new_fill) - AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= i_command;
            r_sel <= i_stack_number;
            r_val <= i_push_value;
        end
        if (i_ctrl.exec) begin
            r_res_empty  <= (new_fill == '0);
            r_res_bypass <= bypass;
            r_res_status <= status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STACKS; i++) begin
                r_fill[i] <= '0;
            end
        end else if (i_ctrl.exec && valid_sel) begin
            case (r_sel)
                2'd1: r_fill[0] <= new_fill;
                2'd2: r_fill[1] <= new_fill;
                2'd3: r_fill[2] <= new_fill;
                default: r_fill[0] <= r_fill[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec && wr_en) begin
            r_mem[wr_addr] <= r_val;
        end
        if (i_ctrl.exec && !bypass && (new_fill != '0)) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_top_value   = r_res_empty  ? '1    :
                           r_res_bypass ? r_val : r_rd_data;
    assign o_stack_empty = r_res_empty;
    assign o_status      = r_res_status;

endmodule

@@ hdl/tsm_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the three-stack memory block, with its bind.
// Depends on tsm_pkg and three_stacks_in_one_memory.
module tsm_checker import tsm_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input logic [DATA_W-1:0] o_top_value,
    input logic              o_stack_empty,
    input logic [1:0]        o_status
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted request");

    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a request in progress");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stack_empty) |-> (o_top_value == '1))
        else $error("empty stack reported with a top value other than -1");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STAT_EMPTY)) |-> o_stack_empty)
        else $error("pop on empty reported for a stack that is not empty");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == STAT_OK || o_status == STAT_FULL ||
                     o_status == STAT_EMPTY))
        else $error("undefined status code");

endmodule

bind three_stacks_in_one_memory tsm_checker u_tsm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_top_value   (o_top_value),
    .o_stack_empty (o_stack_empty),
    .o_status      (o_status)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for three_stacks_in_one_memory. It sends directed and random
// peek, push and pop requests and checks every result against a scoreboard model.
// Depends on tsm_pkg and the three_stacks_in_one_memory top level.
module testbench;
    import tsm_pkg::*;

    localparam int unsigned CAPACITY = 128;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 450;
    localparam int TAIL_CYCLES = 8;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam logic [1:0] NO_STACK = 2'd0;

    typedef struct {
        logic [DATA_W-1:0] top_value;
        logic              stack_empty;
        t_status           status;
    } t_stack_result;

    class stack_tracker #(int unsigned CAP = 128);
        logic [DATA_W-1:0] contents [NUM_STACKS][CAP];
        int unsigned depth [NUM_STACKS];
        t_stack_result pending [$];
        int errors;
        int checked;
        int refused_pushes;
        int ignored_pops;

        function new();
            foreach (depth[i]) depth[i] = 0;
            errors = 0;
            checked = 0;
            refused_pushes = 0;
            ignored_pops = 0;
        endfunction

        function void note_request(logic [1:0] cmd, logic [1:0] sel, logic [DATA_W-1:0] value);
            t_stack_result res;
            int unsigned s;
            int unsigned n;
            res.top_value = '1;
            res.stack_empty = 1'b1;
            res.status = STAT_OK;
            if (sel != NO_STACK) begin
                s = sel - 1;
                n = depth[s];
                if (cmd == CMD_PUSH) begin
                    if (n >= CAP) begin
                        res.status = STAT_FULL;
                        refused_pushes++;
                    end else begin
                        contents[s][n] = value;
                        n++;
                    end
                end else if (cmd == CMD_POP) begin
                    if (n == 0) begin
                        res.status = STAT_EMPTY;
                        ignored_pops++;
                    end else begin
                        n--;
                    end
                end
                depth[s] = n;
                if (n != 0) begin
                    res.top_value = contents[s][n - 1];
                    res.stack_empty = 1'b0;
                end
            end
            pending.push_back(res);
        endfunction

        function void check_result(logic [DATA_W-1:0] top_value, logic stack_empty,
                                   logic [1:0] status);
            t_stack_result want;
            if (pending.size() == 0) begin
                $error("result with no request outstanding: top_value %h", top_value);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (top_value !== want.top_value) begin
                $error("top_value: expected %h, got %h", want.top_value, top_value);
                errors++;
            end
            if (stack_empty !== want.stack_empty) begin
                $error("stack_empty: expected %b, got %b", want.stack_empty, stack_empty);
                errors++;
            end
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_command;
    logic [1:0]        i_stack_number;
    logic [DATA_W-1:0] i_push_value;
    logic              o_valid;
    logic [DATA_W-1:0] o_top_value;
    logic              o_stack_empty;
    logic [1:0]        o_status;

    stack_tracker #(CAPACITY) tracker;
    int idle_pct;
    int stack_requests;
    int idle_cycles;

    three_stacks_in_one_memory #(.CAPACITY(CAPACITY)) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_stack_number (i_stack_number),
        .i_push_value   (i_push_value),
        .o_valid        (o_valid),
        .o_top_value    (o_top_value),
        .o_stack_empty  (o_stack_empty),
        .o_status       (o_status)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            tracker.note_request(i_command, i_stack_number, i_push_value);
        end
        if (i_rst_n && o_valid) begin
            tracker.check_result(o_top_value, o_stack_empty, o_status);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Watchdog expired after %0d cycles without progress.", WATCHDOG_LIMIT);
        $display("testbench: FAIL");
        $finish;
    end

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic issue_request(input logic [1:0] cmd, input logic [1:0] sel,
                                 input logic [DATA_W-1:0] value);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            i_command <= 2'($urandom_range(3));
            i_stack_number <= 2'($urandom_range(3));
            i_push_value <= $urandom;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_command <= cmd;
        i_stack_number <= sel;
        i_push_value <= value;
        if (sel != NO_STACK) stack_requests++;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic run_phase(input int pct);
        int target;
        int mode;
        int len;
        logic [1:0] sel;
        idle_pct = pct;
        target = stack_requests + ITEMS_PER_PHASE;
        while (stack_requests < target) begin
            mode = $urandom_range(15);
            sel = 2'($urandom_range(1, 3));
            if (mode == 0) begin
                len = CAPACITY + $urandom_range(1, 4);
                repeat (len) issue_request(CMD_PUSH, sel, rand_value());
            end else if (mode == 1) begin
                len = CAPACITY + $urandom_range(1, 4);
                repeat (len) issue_request(CMD_POP, sel, $urandom);
            end else if (mode <= 7) begin
                len = $urandom_range(1, 40);
                repeat (len) issue_request(CMD_PUSH, sel, rand_value());
            end else if (mode <= 11) begin
                len = $urandom_range(1, 40);
                repeat (len) issue_request(CMD_POP, sel, $urandom);
            end else if (mode <= 14) begin
                len = $urandom_range(1, 20);
                repeat (len) begin
                    issue_request(2'($urandom_range(3)), 2'($urandom_range(3)), rand_value());
                end
            end else begin
                len = $urandom_range(1, 4);
                repeat (len) begin
                    if ($urandom_range(1)) begin
                        issue_request(2'($urandom_range(3)), NO_STACK, $urandom);
                    end else begin
                        issue_request(CMD_SPARE, sel, $urandom);
                    end
                end
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_command = CMD_PEEK;
        i_stack_number = NO_STACK;
        i_push_value = '0;
        idle_pct = 0;
        stack_requests = 0;
        tracker = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue_request(CMD_PEEK, 2'd1, 32'h1234_5678);
        issue_request(CMD_POP, 2'd1, '0);
        issue_request(CMD_PUSH, 2'd1, 32'h7FFF_FFFF);
        issue_request(CMD_PUSH, 2'd1, 32'h8000_0000);
        issue_request(CMD_PEEK, 2'd1, '1);
        issue_request(CMD_PUSH, 2'd2, '1);
        issue_request(CMD_PUSH, 2'd3, '0);
        issue_request(CMD_SPARE, 2'd2, 32'hDEAD_BEEF);
        issue_request(CMD_POP, 2'd2, '0);
        issue_request(CMD_POP, 2'd2, '0);
        issue_request(CMD_PUSH, 2'd2, 32'h5555_5555);
        issue_request(CMD_PUSH, 2'd2, 32'hAAAA_AAAA);
        issue_request(CMD_PEEK, NO_STACK, '0);
        issue_request(CMD_PUSH, NO_STACK, 32'hCAFE_F00D);
        issue_request(CMD_POP, NO_STACK, '0);
        issue_request(CMD_SPARE, NO_STACK, '1);
        issue_request(CMD_POP, 2'd1, '0);
        issue_request(CMD_POP, 2'd1, '0);
        issue_request(CMD_PEEK, 2'd1, '0);
        issue_request(CMD_POP, 2'd3, '0);
        issue_request(CMD_PEEK, 2'd3, '0);
        issue_request(CMD_POP, 2'd2, '0);
        issue_request(CMD_SPARE, 2'd2, '0);

        run_phase(0);
        run_phase(76);
        run_phase(0);
        run_phase(14);
        start <= 1'b0;

        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d stack requests and %0d checked results.",
                 stack_requests, tracker.checked);
        $display("Full stacks refused %0d pushes; empty stacks ignored %0d pops.",
                 tracker.refused_pushes, tracker.ignored_pops);
        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
